// ===== sv/egd_pkg.sv =====
// shared types and constants for the edge gradient/direction block
// no dependencies
`default_nettype none
package egd_pkg;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAG_BITS = 25;
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    OP_CDIFF   = 3'd0,
    OP_PREWITT = 3'd1,
    OP_SOBEL   = 3'd2,
    OP_SCHARR  = 3'd3,
    OP_K17     = 3'd4
  } op_t;

  localparam logic CFG_OP  = 1'b0;
  localparam logic CFG_DIR = 1'b1;
  localparam logic [2:0] OP_RESET = 3'd2;

  typedef struct packed {
    logic [15:0] l0, l1, l2;
    logic [15:0] c0, c2;
    logic [15:0] r0, r1, r2;
    logic        row_end;
  } win_t;

  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_ONE  = 2'd1,
    HELD_TWO  = 2'd2
  } held_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_GRAD = 3'd1,
    S_SQ   = 3'd2,
    S_ROOT = 3'd3,
    S_DONE = 3'd4
  } back_state_t;
endpackage
`default_nettype wire

// ===== sv/edge_gradient_direction.sv =====
// edge gradient magnitude and direction, top level
// path from item accept to result valid: queue, gradient register, absolute values, squares, serial square root
// the back end takes no new window until the result of the last one has been taken
// a flush column yields two results (one if it is also the first column); front accepts while the queue has room
// reset (rst, synchronous) clears the window, the queue and sets operator 2, direction on
`default_nettype none
module edge_gradient_direction #(
  parameter int SAMPLE_BITS = egd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [2:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] top_sample,
  input  wire logic [15:0] middle_sample,
  input  wire logic [15:0] bottom_sample,
  input  wire logic        first_column,
  input  wire logic        last_column,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [24:0]      magnitude,
  output logic [1:0]       direction_bin,
  output logic             row_end
);
  logic [2:0] operator_select;
  logic       direction_enable;
  logic fw_valid, fw_ready, bw_valid, bw_ready;
  egd_pkg::win_t fw, bw;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      operator_select <= egd_pkg::OP_RESET;
      direction_enable <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == egd_pkg::CFG_OP) operator_select <= cfg_data;
      else direction_enable <= cfg_data[0];
    end
  end

  egd_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst, .top_sample, .middle_sample, .bottom_sample, .first_column,
    .last_column, .in_valid, .in_ready, .win_valid(fw_valid), .win(fw),
    .win_ready(fw_ready));

  egd_fifo u_fifo (
    .clk, .rst, .wr_valid(fw_valid), .wr_ready(fw_ready), .wr_data(fw),
    .rd_valid(bw_valid), .rd_ready(bw_ready), .rd_data(bw));

  egd_back u_back (
    .clk, .rst, .operator_select, .direction_enable, .win_valid(bw_valid),
    .win_ready(bw_ready), .win(bw), .out_valid, .out_ready, .magnitude,
    .direction_bin, .row_end);
endmodule
`default_nettype wire

// ===== sv/egd_front.sv =====
// front: column window, mirroring and row flush; emits 3x3 windows
// depends on egd_pkg
`default_nettype none
module egd_front #(
  parameter int SAMPLE_BITS = egd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] top_sample,
  input  wire logic [15:0] middle_sample,
  input  wire logic [15:0] bottom_sample,
  input  wire logic        first_column,
  input  wire logic        last_column,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             win_valid,
  output egd_pkg::win_t    win,
  input  wire logic        win_ready
);
  localparam logic [15:0] SMASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);
  logic [15:0] older [3];
  logic [15:0] newer [3];
  logic [15:0] col [3];
  egd_pkg::held_t held, held_eff;
  logic        pend, pend_next;
  egd_pkg::win_t pend_win;
  logic        acc;

  assign col[0] = top_sample & SMASK;
  assign col[1] = middle_sample & SMASK;
  assign col[2] = bottom_sample & SMASK;
  assign held_eff = first_column ? egd_pkg::HELD_NONE : held;

  // a flush item after an earlier column produces a second window, held here until the queue takes it
  assign in_ready = !pend && win_ready;
  assign acc = in_valid && in_ready;

  always_comb begin
    win_valid = 1'b0;
    win = '0;
    pend_next = 1'b0;
    if (pend) begin
      win_valid = 1'b1;
      win = pend_win;
    end else if (in_valid && held_eff != egd_pkg::HELD_NONE) begin
      win_valid = 1'b1;
      win = '{l0: older[0], l1: older[1], l2: older[2], c0: newer[0], c2: newer[2],
              r0: col[0], r1: col[1], r2: col[2], row_end: 1'b0};
      if (held_eff == egd_pkg::HELD_ONE) begin
        win.l0 = col[0]; win.l1 = col[1]; win.l2 = col[2];
      end
      pend_next = last_column;
    end else if (in_valid && last_column) begin
      win_valid = 1'b1;
      win = '{l0: col[0], l1: col[1], l2: col[2], c0: col[0], c2: col[2],
              r0: col[0], r1: col[1], r2: col[2], row_end: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= egd_pkg::HELD_NONE;
      pend <= 1'b0;
    end else begin
      if (pend && win_ready) pend <= 1'b0;
      if (acc) begin
        pend <= pend_next;
        if (held_eff == egd_pkg::HELD_NONE)
          held <= last_column ? egd_pkg::HELD_NONE : egd_pkg::HELD_ONE;
        else
          held <= last_column ? egd_pkg::HELD_NONE : egd_pkg::HELD_TWO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < 3; i++) begin
        older[i] <= newer[i];
        newer[i] <= col[i];
      end
      pend_win <= '{l0: newer[0], l1: newer[1], l2: newer[2], c0: col[0], c2: col[2],
                    r0: newer[0], r1: newer[1], r2: newer[2], row_end: 1'b1};
    end
  end
endmodule
`default_nettype wire

// ===== sv/egd_fifo.sv =====
// short window queue between front and back
// depends on egd_pkg
`default_nettype none
module egd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire egd_pkg::win_t wr_data,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output egd_pkg::win_t      rd_data
);
  egd_pkg::win_t mem [egd_pkg::QDEPTH];
  logic wp, rp;
  logic [1:0] cnt;
  logic wr, rd;
  assign wr_ready = cnt != 2'(egd_pkg::QDEPTH);
  assign rd_valid = cnt != 2'd0;
  assign rd_data = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (wr) wp <= !wp;
      if (rd) rp <= !rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end
  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end
endmodule
`default_nettype wire

// ===== sv/egd_back.sv =====
// back: gradients, squares, serial square root and direction bin
// depends on egd_pkg
`default_nettype none
module egd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [2:0]    operator_select,
  input  wire logic          direction_enable,
  input  wire logic          win_valid,
  output logic               win_ready,
  input  wire egd_pkg::win_t win,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [24:0]        magnitude,
  output logic [1:0]         direction_bin,
  output logic               row_end
);
  egd_pkg::back_state_t st, st_next;
  // gradients (doubled except for Prewitt) fit in 26 bits signed (|G| <= 2*95*65535)
  logic signed [25:0] gx, gy, gx_n, gy_n;
  logic [24:0] ax, ay;
  logic [49:0] sx, sy, t1a, t3d;
  logic [49:0] rem;
  logic [25:0] sum;
  logic [25:0] root;
  logic [4:0]  it;
  logic        end_r, gxneg, b_le_a;
  logic        take_out;
  logic [2:0]  op;
  logic signed [25:0] dr, dc, el, er;
  logic [6:0]  ew, mw;
  logic [1:0]  s2;
  logic [51:0] rad;
  logic [1:0]  pair;
  logic [51:0] trial;
  logic [50:0] twoa2;
  logic        bt1, bt3;

  assign op = operator_select > 3'd4 ? 3'd4 : operator_select;

  always_comb begin
    ew = 7'd0; mw = 7'd0; s2 = 2'd2;
    case (egd_pkg::op_t'(op))
      egd_pkg::OP_CDIFF:   begin ew = 7'd0;  mw = 7'd1;  s2 = 2'd2; end
      egd_pkg::OP_PREWITT: begin ew = 7'd1;  mw = 7'd1;  s2 = 2'd1; end
      egd_pkg::OP_SOBEL:   begin ew = 7'd1;  mw = 7'd2;  s2 = 2'd2; end
      egd_pkg::OP_SCHARR:  begin ew = 7'd3;  mw = 7'd10; s2 = 2'd2; end
      default:             begin ew = 7'd17; mw = 7'd61; s2 = 2'd2; end
    endcase
  end

  always_comb begin
    dr = $signed({10'd0, win.r1}) - $signed({10'd0, win.l1});
    dc = $signed({10'd0, win.c0}) - $signed({10'd0, win.c2});
    el = $signed({10'd0, win.r0}) + $signed({10'd0, win.r2})
       - $signed({10'd0, win.l0}) - $signed({10'd0, win.l2});
    er = $signed({10'd0, win.l0}) + $signed({10'd0, win.r0})
       - $signed({10'd0, win.l2}) - $signed({10'd0, win.r2});
    gx_n = 26'(($signed({1'b0, ew}) * el + $signed({1'b0, mw}) * dr)
           * $signed({1'b0, s2}));
    gy_n = 26'(($signed({1'b0, ew}) * er + $signed({1'b0, mw}) * dc)
           * $signed({1'b0, s2}));
  end

  assign take_out = out_valid && out_ready;

  always_comb begin
    st_next = st;
    case (st)
      egd_pkg::S_IDLE: if (win_valid) st_next = egd_pkg::S_GRAD;
      egd_pkg::S_GRAD: st_next = egd_pkg::S_SQ;
      egd_pkg::S_SQ:   st_next = egd_pkg::S_ROOT;
      egd_pkg::S_ROOT: if (it == 5'd0) st_next = egd_pkg::S_DONE;
      egd_pkg::S_DONE: if (take_out) st_next = egd_pkg::S_IDLE;
      default: st_next = egd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    win_ready = st == egd_pkg::S_IDLE;
    out_valid = st == egd_pkg::S_DONE;
    magnitude = root[24:0];
  end

  assign sum = {1'b0, ax} + {1'b0, ay};

  always_ff @(posedge clk) begin
    if (rst) st <= egd_pkg::S_IDLE;
    else st <= st_next;
  end

  // square root: restoring, one result bit per cycle, for all 26 bits of the root
  assign rad = {2'b00, sx + sy};
  assign pair = 2'(rad >> {it, 1'b0});
  assign trial = {rem, pair};

  always_ff @(posedge clk) begin
    case (st)
      egd_pkg::S_IDLE: if (win_valid) begin
        gx <= gx_n; gy <= gy_n; end_r <= win.row_end;
      end
      egd_pkg::S_GRAD: begin
        ax <= gx[25] ? 25'(-gx) : 25'(gx);
        ay <= gy[25] ? 25'(-gy) : 25'(gy);
        gxneg <= (gx[25] != gy[25]) && gx != 26'sd0;
      end
      egd_pkg::S_SQ: begin
        sx <= 50'(ax) * 50'(ax);
        sy <= 50'(ay) * 50'(ay);
        b_le_a <= ay <= ax;
        t1a <= 50'(sum) * 50'(sum);
        t3d <= 50'(ay - ax) * 50'(ay - ax);
        rem <= '0; root <= '0; it <= 5'd25;
      end
      egd_pkg::S_ROOT: begin
        if (trial >= {24'd0, root, 2'b01}) begin
          rem <= 50'(trial - {24'd0, root, 2'b01});
          root <= {root[24:0], 1'b1};
        end else begin
          rem <= 50'(trial);
          root <= {root[24:0], 1'b0};
        end
        it <= it - 5'd1;
      end
      egd_pkg::S_DONE: ;
      default: ;
    endcase
  end

  // direction from squared terms (exact integer tangent tests)
  assign twoa2 = {sx, 1'b0};
  assign bt1 = {1'b0, t1a} < twoa2;
  assign bt3 = b_le_a || ({1'b0, t3d} < twoa2);
  always_comb begin
    if (!direction_enable || ay == 25'd0) direction_bin = 2'd0;
    else if (!gxneg) direction_bin = bt1 ? 2'd0 : (bt3 ? 2'd1 : 2'd2);
    else direction_bin = !bt3 ? 2'd2 : (!bt1 ? 2'd3 : 2'd0);
  end
  assign row_end = end_r;
endmodule
`default_nettype wire
